[sv/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sumo tactics controller
// Item layouts, state layout, configuration register set and fixed timings.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeAttack  = 2'd1,
    ModeDefence = 2'd2,
    ModeSearch  = 2'd3
  } srt_mode_e;

  typedef enum logic [2:0] {
    SpLeft  = 3'd0,
    SpRight = 3'd1,
    SpPause = 3'd2,
    SpBrake = 3'd3,
    SpSpin  = 3'd4
  } srt_search_e;

  typedef enum logic [1:0] {
    EscNone    = 2'd0,
    EscSpin    = 2'd1,
    EscRun     = 2'd2,
    EscReverse = 2'd3
  } srt_escape_e;

  typedef enum logic [2:0] {
    ApCharge     = 3'd0,
    ApAlignLeft  = 3'd1,
    ApPauseLeft  = 3'd2,
    ApAlignRight = 3'd3,
    ApPauseRight = 3'd4,
    ApFinalTurn  = 3'd5
  } srt_align_e;

  typedef enum logic [2:0] {
    CfgAttackThr  = 3'd0,
    CfgSearchTurn = 3'd1,
    CfgSearchPause = 3'd2,
    CfgSearchSpin = 3'd3,
    CfgDefSpin    = 3'd4,
    CfgDefEscape  = 3'd5,
    CfgAlignTurn  = 3'd6,
    CfgMinDuty    = 3'd7
  } srt_cfg_idx_e;

  localparam logic DirFwd  = 1'b0;
  localparam logic DirBack = 1'b1;

  localparam logic [9:0]  FarQ4        = 10'd960;
  localparam logic [31:0] EscReverseMs = 32'd200;
  localparam logic [31:0] BrakeMs      = 32'd50;
  localparam logic [31:0] AlignPauseMs = 32'd100;
  localparam logic [31:0] FinalTurnMs  = 32'd300;
  localparam logic [31:0] SteerMs      = 32'd400;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        start_pressed;
    logic        line_front;
    logic        line_right;
    logic        line_back_right;
    logic        line_back_left;
    logic        line_left;
    logic [9:0]  distance_q4;
  } srt_in_t;

  typedef struct packed {
    logic       dir_a;
    logic [7:0] duty_a;
    logic       dir_b;
    logic [7:0] duty_b;
  } srt_drive_t;

  typedef struct packed {
    srt_mode_e  mode;
    srt_drive_t drv;
  } srt_out_t;

  typedef struct packed {
    logic [9:0]  attack_threshold_q4;
    logic [15:0] search_turn_ms;
    logic [15:0] search_pause_ms;
    logic [15:0] search_spin_ms;
    logic [15:0] defence_spin_ms;
    logic [15:0] defence_escape_ms;
    logic [15:0] align_turn_ms;
    logic [7:0]  min_duty;
  } srt_cfg_t;

  localparam srt_cfg_t CfgReset = '{
    attack_threshold_q4: 10'd880,
    search_turn_ms:      16'd400,
    search_pause_ms:     16'd100,
    search_spin_ms:      16'd900,
    defence_spin_ms:     16'd450,
    defence_escape_ms:   16'd800,
    align_turn_ms:       16'd100,
    min_duty:            8'd80
  };

  typedef struct packed {
    srt_mode_e   mode;
    srt_search_e search_phase;
    logic        last_sweep_right;
    logic        sweep_done;
    logic [31:0] search_since;
    srt_escape_e escape_phase;
    logic [31:0] escape_since;
    logic [31:0] charge_since;
    srt_align_e  align_phase;
    logic [31:0] align_since;
    logic        bias_right;
    logic [9:0]  left_distance;
    logic [9:0]  right_distance;
    srt_drive_t  drv;
  } srt_state_t;

  localparam srt_state_t StateReset = '{
    mode:             ModeIdle,
    search_phase:     SpPause,
    last_sweep_right: 1'b1,
    sweep_done:       1'b0,
    search_since:     32'd0,
    escape_phase:     EscNone,
    escape_since:     32'd0,
    charge_since:     32'd0,
    align_phase:      ApCharge,
    align_since:      32'd0,
    bias_right:       1'b0,
    left_distance:    FarQ4,
    right_distance:   FarQ4,
    drv:              '{dir_a: DirFwd, duty_a: 8'd0, dir_b: DirFwd, duty_b: 8'd0}
  };

endpackage

`default_nettype wire

[sv/srt_step.sv]
// ----------------------------------------------------------------------------
// srt_step: one control pass of the tactics controller
// Pure next-state logic: current state, configuration and sensor item in,
// next state out. The result item is the mode and drive of the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_step
  import srt_pkg::*;
(
  input  srt_state_t state_i,
  input  srt_cfg_t   cfg_i,
  input  srt_in_t    item_i,
  output srt_state_t state_o
);

  function automatic logic [7:0] raise_duty(input logic [7:0] d, input logic [7:0] lo);
    raise_duty = (d != 8'd0 && d < lo) ? lo : d;
  endfunction

  always_comb begin
    srt_state_t  n;
    logic [31:0] now;
    logic [9:0]  range_q4;
    logic        hit;
    logic [17:0] window;
    logic [31:0] el;

    n        = state_i;
    now      = item_i.now_ms;
    range_q4 = item_i.distance_q4;
    hit      = item_i.line_front | item_i.line_right | item_i.line_back_right |
               item_i.line_back_left | item_i.line_left;
    window   = 18'(EscReverseMs) + 18'(cfg_i.defence_spin_ms) +
               18'(cfg_i.defence_escape_ms);
    el       = '0;

    if (n.mode == ModeIdle) begin
      n.drv.duty_a = 8'd0;
      n.drv.duty_b = 8'd0;
      if (item_i.start_pressed) begin
        n.mode             = ModeSearch;
        n.search_since     = now;
        n.search_phase     = SpPause;
        n.last_sweep_right = 1'b1;
        n.sweep_done       = 1'b0;
      end
    end else begin
      // mode choice, fixed priority
      if (hit || n.escape_phase != EscNone ||
          (n.mode == ModeDefence && (now - n.escape_since) < 32'(window))) begin
        n.mode = ModeDefence;
      end else if (range_q4 >= FarQ4 || range_q4 >= cfg_i.attack_threshold_q4) begin
        if (n.mode != ModeSearch) begin
          n.mode             = ModeSearch;
          n.search_since     = now;
          n.search_phase     = SpPause;
          n.last_sweep_right = 1'b1;
          n.sweep_done       = 1'b0;
          n.drv.duty_a       = 8'd0;
          n.drv.duty_b       = 8'd0;
        end
      end else begin
        if (n.mode != ModeAttack) begin
          n.charge_since = now;
          if (n.mode == ModeSearch) begin
            if (n.search_phase == SpLeft)       n.bias_right = 1'b0;
            else if (n.search_phase == SpRight) n.bias_right = 1'b1;
            else                                n.bias_right = n.last_sweep_right;
          end else begin
            n.bias_right = 1'b0;
          end
          n.align_phase    = ApAlignLeft;
          n.align_since    = now;
          n.left_distance  = FarQ4;
          n.right_distance = FarQ4;
        end
        n.mode = ModeAttack;
      end

      unique case (n.mode)
        ModeAttack: begin
          el = now - n.align_since;
          case (n.align_phase)
            ApCharge: begin
              if ((now - n.charge_since) < SteerMs) begin
                if (n.bias_right) n.drv = '{DirFwd, 8'd220, DirFwd, 8'd140};
                else              n.drv = '{DirFwd, 8'd120, DirFwd, 8'd255};
              end else begin
                n.drv = '{DirFwd, 8'd250, DirFwd, 8'd250};
              end
            end
            ApAlignLeft: begin
              n.drv = '{DirBack, 8'd100, DirFwd, 8'd100};
              if (el >= 32'(cfg_i.align_turn_ms)) begin
                n.align_phase = ApPauseLeft;
                n.align_since = now;
                n.drv.duty_a  = 8'd0;
                n.drv.duty_b  = 8'd0;
              end
            end
            ApPauseLeft: begin
              n.drv.duty_a = 8'd0;
              n.drv.duty_b = 8'd0;
              if (el >= AlignPauseMs) begin
                n.left_distance = range_q4;
                n.align_phase   = ApAlignRight;
                n.align_since   = now;
              end
            end
            ApAlignRight: begin
              n.drv = '{DirFwd, 8'd100, DirBack, 8'd100};
              if (el >= {15'd0, cfg_i.align_turn_ms, 1'b0}) begin
                n.align_phase = ApPauseRight;
                n.align_since = now;
                n.drv.duty_a  = 8'd0;
                n.drv.duty_b  = 8'd0;
              end
            end
            ApPauseRight: begin
              n.drv.duty_a = 8'd0;
              n.drv.duty_b = 8'd0;
              if (el >= AlignPauseMs) begin
                n.right_distance = range_q4;
                n.align_phase    = ApFinalTurn;
                n.align_since    = now;
                if (n.left_distance < range_q4) n.drv = '{DirBack, 8'd150, DirFwd, 8'd150};
                else                            n.drv = '{DirFwd, 8'd150, DirBack, 8'd150};
              end
            end
            ApFinalTurn: begin
              if (el >= FinalTurnMs) begin
                n.align_phase  = ApCharge;
                n.charge_since = now;
                n.drv.duty_a   = 8'd0;
                n.drv.duty_b   = 8'd0;
              end
            end
            default: ;
          endcase
        end

        ModeDefence: begin
          el = now - n.escape_since;
          if (item_i.line_front || n.escape_phase != EscNone) begin
            priority if (n.escape_phase == EscNone) begin
              n.escape_phase = EscReverse;
              n.escape_since = now;
              n.drv          = '{DirBack, 8'd150, DirBack, 8'd150};
            end else if (n.escape_phase == EscReverse && el >= EscReverseMs) begin
              n.escape_phase = EscSpin;
              n.escape_since = now;
              n.drv          = '{DirFwd, 8'd255, DirBack, 8'd255};
            end else if (n.escape_phase == EscSpin &&
                         el >= 32'(cfg_i.defence_spin_ms)) begin
              n.escape_phase = EscRun;
              n.escape_since = now;
              n.drv          = '{DirFwd, 8'd255, DirFwd, 8'd255};
            end else if (n.escape_phase == EscRun &&
                         el >= 32'(cfg_i.defence_escape_ms)) begin
              n.escape_phase = EscNone;
              n.drv.duty_a   = 8'd0;
              n.drv.duty_b   = 8'd0;
            end else begin
              // phase still timing: hold drive
            end
          end else begin
            n.escape_phase = EscNone;
            priority if (item_i.line_left) begin
              n.drv = '{DirFwd, 8'd250, DirFwd, 8'd150};
            end else if (item_i.line_right) begin
              n.drv = '{DirFwd, 8'd150, DirFwd, 8'd250};
            end else if (item_i.line_back_right || item_i.line_back_left) begin
              n.drv = '{DirFwd, 8'd250, DirFwd, 8'd250};
            end else begin
              n.drv.duty_a = 8'd0;
              n.drv.duty_b = 8'd0;
            end
          end
        end

        ModeSearch: begin
          el = now - n.search_since;
          if (range_q4 < cfg_i.attack_threshold_q4) begin
            // threshold above the far cap: flip to attack, drive untouched
            n.mode       = ModeAttack;
            n.sweep_done = 1'b0;
          end else begin
            case (n.search_phase)
              SpLeft: begin
                n.drv = '{DirBack, 8'd220, DirFwd, 8'd220};
                if (el >= 32'(cfg_i.search_turn_ms)) begin
                  n.search_phase     = SpBrake;
                  n.last_sweep_right = 1'b0;
                  n.search_since     = now;
                end
              end
              SpRight: begin
                n.drv = '{DirFwd, 8'd150, DirBack, 8'd150};
                if (el >= 32'(cfg_i.search_turn_ms)) begin
                  n.search_phase     = SpBrake;
                  n.last_sweep_right = 1'b1;
                  n.sweep_done       = 1'b1;
                  n.search_since     = now;
                end
              end
              SpBrake: begin
                n.drv = '{DirBack, 8'd100, DirBack, 8'd100};
                if (el >= BrakeMs) begin
                  n.search_phase = (n.sweep_done && n.last_sweep_right) ? SpSpin : SpPause;
                  n.search_since = now;
                end
              end
              SpPause: begin
                n.drv.duty_a = 8'd0;
                n.drv.duty_b = 8'd0;
                if (el >= 32'(cfg_i.search_pause_ms)) begin
                  n.search_phase = n.last_sweep_right ? SpLeft : SpRight;
                  n.search_since = now;
                end
              end
              SpSpin: begin
                n.drv = '{DirFwd, 8'd255, DirBack, 8'd255};
                if (el >= 32'(cfg_i.search_spin_ms)) begin
                  n.search_phase = SpPause;
                  n.sweep_done   = 1'b0;
                  n.search_since = now;
                end
              end
              default: ;
            endcase
          end
        end

        ModeIdle: ;
      endcase

      n.drv.duty_a = raise_duty(n.drv.duty_a, cfg_i.min_duty);
      n.drv.duty_b = raise_duty(n.drv.duty_b, cfg_i.min_duty);
    end

    state_o = n;
  end

endmodule

`default_nettype wire

[sv/sumo_robot_tactics_fsm_top.sv]
// ----------------------------------------------------------------------------
// sumo_robot_tactics_fsm_top: sumo-robot tactics controller
// Each sensor item advances the tactics state by one control pass and
// yields one drive item (mode, motor directions and duties).
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one sensor item per
//    control pass. An item is taken on a rising edge with valid high and
//    stall low.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one drive item
//    per sensor item, in order.
//  - Config channel (cfg_valid_i / cfg_ready_o): ready is always high; write
//    only while no item is in flight.
//  - Latency: the drive item sits in the output register the cycle after its
//    sensor item is taken. Throughput: one item per cycle while not stalled,
//    set by the single pass of next-state logic between the state and result registers.
//  - Stall: while the output register holds an item that is stalled, the input
//    side is stalled too; a draining output register still takes a new item.
//  - Reset: idle mode, forward directions, zero duties, config at defaults,
//    output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sumo_robot_tactics_fsm_top
  import srt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sensor items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srt_in_t             in_data_i,
  // drive items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srt_out_t            out_data_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  srt_cfg_t   cfg_q;
  srt_state_t state_q, state_d;
  logic       out_valid_q;
  srt_out_t   out_q;
  logic       accept;

  // an item can enter whenever the result register is empty or emptying
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (srt_cfg_idx_e'(cfg_index_i))
        CfgAttackThr:   cfg_q.attack_threshold_q4 <= cfg_data_i[9:0];
        CfgSearchTurn:  cfg_q.search_turn_ms      <= cfg_data_i;
        CfgSearchPause: cfg_q.search_pause_ms     <= cfg_data_i;
        CfgSearchSpin:  cfg_q.search_spin_ms      <= cfg_data_i;
        CfgDefSpin:     cfg_q.defence_spin_ms     <= cfg_data_i;
        CfgDefEscape:   cfg_q.defence_escape_ms   <= cfg_data_i;
        CfgAlignTurn:   cfg_q.align_turn_ms       <= cfg_data_i;
        CfgMinDuty:     cfg_q.min_duty            <= cfg_data_i[7:0];
      endcase
    end
  end

  // one control pass
  srt_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (in_data_i),
    .state_o (state_d)
  );

  // tactics state advances only on a taken item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // result register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.mode <= state_d.mode;
      out_q.drv  <= state_d.drv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
